// File: hdl/two_tier_cache_budget_manager_core_defines.svh
// Assertion macros for the two-tier cache budget manager.
// Used by the top level only; define ASSERT_OFF to compile the checks away.
`ifndef TWO_TIER_CACHE_BUDGET_MANAGER_CORE_DEFINES_SVH
`define TWO_TIER_CACHE_BUDGET_MANAGER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TTCBM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TTCBM_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);
`else
`define TTCBM_ASSERT(lbl, prop, msg)
`define TTCBM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: hdl/ttcbm_pkg.sv
// Shared constants, codes and controller/datapath types for the cache budget manager.
// No dependencies.
package ttcbm_pkg;

   localparam int HOT_ENTRIES  = 16;
   localparam int WARM_ENTRIES = 16;
   localparam int KEY_BITS     = 32;
   localparam int SIZE_BITS    = 24;
   localparam int USED_BITS    = 29;
   localparam int BUDGET_BITS  = 32;
   localparam int STAMP_BITS   = 64;
   localparam int ORDER_BITS   = 32;
   localparam int OP_BITS      = 3;
   localparam int EV_BITS      = 3;
   localparam int CSR_IDX_BITS = 1;
   localparam int EVENT_CAP    = 32;
   localparam int RES_CNT_BITS = 6;

   localparam int HOT_IDX_BITS  = (HOT_ENTRIES > 1) ? $clog2(HOT_ENTRIES) : 1;
   localparam int WARM_IDX_BITS = (WARM_ENTRIES > 1) ? $clog2(WARM_ENTRIES) : 1;
   localparam int SCAN_LEN      = (HOT_ENTRIES > WARM_ENTRIES) ? HOT_ENTRIES : WARM_ENTRIES;
   localparam int SCAN_IDX_BITS = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;

   typedef logic [OP_BITS-1:0] opcode_type;
   localparam opcode_type OPC_GET      = 3'd0;
   localparam opcode_type OPC_PUT      = 3'd1;
   localparam opcode_type OPC_PUTC     = 3'd2;
   localparam opcode_type OPC_PIN      = 3'd3;
   localparam opcode_type OPC_CONTAINS = 3'd4;
   localparam opcode_type OPC_CLEAR    = 3'd5;

   typedef logic [EV_BITS-1:0] event_type;
   localparam event_type EV_HOT_HIT   = 3'd0;
   localparam event_type EV_WARM_HIT  = 3'd1;
   localparam event_type EV_MISS      = 3'd2;
   localparam event_type EV_DEMOTED   = 3'd3;
   localparam event_type EV_DISCARDED = 3'd4;
   localparam event_type EV_DONE      = 3'd5;
   localparam event_type EV_FULL      = 3'd6;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;
   localparam csr_idx_type REG_HOT_BUDGET  = 1'd0;
   localparam csr_idx_type REG_WARM_BUDGET = 1'd1;

   typedef enum logic [3:0] {
      DP_NOP, DP_LOAD, DP_SCAN_INIT, DP_SCAN_VIC, DP_STEP, DP_TOUCH, DP_PROMOTE,
      DP_PUT_HOT, DP_PUT_WARM, DP_PIN, DP_CLEAR, DP_DISCARD, DP_DEMOTE, DP_EMIT
   } dp_op_type;

   typedef enum logic [2:0] {
      SZ_ZERO, SZ_REQ, SZ_HOT, SZ_WARM, SZ_EVENT, SZ_PROMO
   } size_sel_type;

   typedef struct packed {
      dp_op_type    op;
      event_type    ev_code;
      logic         key_from_event;
      size_sel_type size_sel;
      logic         with_present;
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic hot_hit;
      logic warm_hit;
      logic hot_free;
      logic warm_free;
      logic lru_found;
      logic old_found;
      logic hot_over;
      logic warm_over;
      logic out_free;
   } status_type;

endpackage

// File: hdl/ttcbm_ifs.sv
// Channel interfaces: request, response and register write.
// Depends on ttcbm_pkg.
interface ttcbm_req_if
   import ttcbm_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [OP_BITS-1:0]   operation;
   logic [KEY_BITS-1:0]  key;
   logic [SIZE_BITS-1:0] chunk_size;
   modport source (output valid, operation, key, chunk_size, input ready);
   modport sink (input valid, operation, key, chunk_size, output ready);
endinterface

interface ttcbm_rsp_if
   import ttcbm_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [EV_BITS-1:0]   event_res;
   logic [KEY_BITS-1:0]  event_key;
   logic [SIZE_BITS-1:0] event_size;
   logic                 present;
   logic [USED_BITS-1:0] hot_used;
   logic [USED_BITS-1:0] warm_used;
   logic                 last;
   modport source (output valid, event_res, event_key, event_size, present, hot_used,
                   warm_used, last, input ready);
   modport sink (input valid, event_res, event_key, event_size, present, hot_used,
                 warm_used, last, output ready);
endinterface

interface ttcbm_csr_if
   import ttcbm_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [BUDGET_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/ttcbm_dp.sv
// Datapath: tier tag stores, byte totals, scan unit, budgets and response register.
// Depends on ttcbm_pkg and the channel interfaces; driven by ttcbm_ctrl commands.
module ttcbm_dp
   import ttcbm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           stat,
   input  logic [KEY_BITS-1:0]  req_key,
   input  logic [SIZE_BITS-1:0] req_size,
   ttcbm_csr_if.sink            csr,
   ttcbm_rsp_if.source          rsp
);

   // Tag stores.
   logic [HOT_ENTRIES-1:0]  hot_valid_ff, hot_valid_in, hot_pinned_ff, hot_pinned_in;
   logic [WARM_ENTRIES-1:0] warm_valid_ff, warm_valid_in;
   logic [KEY_BITS-1:0]     hot_key_ff [HOT_ENTRIES];
   logic [SIZE_BITS-1:0]    hot_size_ff [HOT_ENTRIES];
   logic [STAMP_BITS-1:0]   hot_stamp_ff [HOT_ENTRIES];
   logic [KEY_BITS-1:0]     warm_key_ff [WARM_ENTRIES];
   logic [SIZE_BITS-1:0]    warm_size_ff [WARM_ENTRIES];
   logic [ORDER_BITS-1:0]   warm_order_ff [WARM_ENTRIES];

   logic [STAMP_BITS-1:0]  access_ff, access_in;
   logic [ORDER_BITS-1:0]  insert_ff, insert_in;
   logic [USED_BITS-1:0]   hot_bytes_ff, hot_bytes_in, warm_bytes_ff, warm_bytes_in;
   logic [BUDGET_BITS-1:0] hot_budget_ff, hot_budget_in, warm_budget_ff, warm_budget_in;

   // Request and scan registers.
   logic [KEY_BITS-1:0]      key_ff, key_in, scan_key_ff, scan_key_in;
   logic [SIZE_BITS-1:0]     size_ff, size_in;
   logic [SCAN_IDX_BITS-1:0] idx_ff, idx_in;
   logic                     hhit_ff, hhit_in, whit_ff, whit_in, lru_ff, lru_in, old_ff, old_in;
   logic [HOT_IDX_BITS-1:0]  hhit_idx_ff, hhit_idx_in, lru_idx_ff, lru_idx_in;
   logic [WARM_IDX_BITS-1:0] whit_idx_ff, whit_idx_in, old_idx_ff, old_idx_in;
   logic [STAMP_BITS-1:0]    lru_age_ff, lru_age_in;
   logic [ORDER_BITS-1:0]    old_age_ff, old_age_in;
   logic [KEY_BITS-1:0]      dem_key_ff, dem_key_in, ev_key_ff, ev_key_in;
   logic [SIZE_BITS-1:0]     dem_size_ff, dem_size_in, ev_size_ff, ev_size_in;
   logic [SIZE_BITS-1:0]     promo_ff, promo_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [EV_BITS-1:0]   rsp_code_ff, rsp_code_in;
   logic [KEY_BITS-1:0]  rsp_key_ff, rsp_key_in;
   logic [SIZE_BITS-1:0] rsp_size_ff, rsp_size_in;
   logic                 rsp_pres_ff, rsp_pres_in, rsp_last_ff, rsp_last_in;
   logic [USED_BITS-1:0] rsp_hot_ff, rsp_hot_in, rsp_warm_ff, rsp_warm_in;

   // Read ports, write ports and free-slot search.
   logic [HOT_IDX_BITS-1:0]  hot_ra, hot_wa, hot_free_idx;
   logic [WARM_IDX_BITS-1:0] warm_ra, warm_wa, warm_free_idx;
   logic                     hot_free, warm_free, hot_in_range, warm_in_range;
   logic [KEY_BITS-1:0]      hot_rd_key, warm_rd_key, hot_wkey, warm_wkey;
   logic [SIZE_BITS-1:0]     hot_rd_size, warm_rd_size, hot_wsize, warm_wsize;
   logic [STAMP_BITS-1:0]    hot_age;
   logic [ORDER_BITS-1:0]    warm_age;
   logic                     hot_wr_data, hot_wr_stamp, warm_wr;

   always_comb begin
      unique case (cmd.op)
         DP_STEP:     hot_ra = idx_ff[HOT_IDX_BITS-1:0];
         DP_SCAN_VIC: hot_ra = lru_idx_ff;
         default:     hot_ra = hhit_idx_ff;
      endcase
      unique case (cmd.op)
         DP_STEP:    warm_ra = idx_ff[WARM_IDX_BITS-1:0];
         DP_DISCARD: warm_ra = old_idx_ff;
         default:    warm_ra = whit_idx_ff;
      endcase
   end

   assign hot_rd_key    = hot_key_ff[hot_ra];
   assign hot_rd_size   = hot_size_ff[hot_ra];
   assign hot_age       = access_ff - hot_stamp_ff[hot_ra];
   assign warm_rd_key   = warm_key_ff[warm_ra];
   assign warm_rd_size  = warm_size_ff[warm_ra];
   assign warm_age      = insert_ff - warm_order_ff[warm_ra];
   assign hot_in_range  = int'(idx_ff) < HOT_ENTRIES;
   assign warm_in_range = int'(idx_ff) < WARM_ENTRIES;

   always_comb begin
      hot_free     = 1'b0;
      hot_free_idx = '0;
      for (int i = HOT_ENTRIES - 1; i >= 0; i--) begin
         if (!hot_valid_ff[i]) begin
            hot_free     = 1'b1;
            hot_free_idx = HOT_IDX_BITS'(i);
         end
      end
      warm_free     = 1'b0;
      warm_free_idx = '0;
      for (int i = WARM_ENTRIES - 1; i >= 0; i--) begin
         if (!warm_valid_ff[i]) begin
            warm_free     = 1'b1;
            warm_free_idx = WARM_IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      hot_valid_in   = hot_valid_ff;
      hot_pinned_in  = hot_pinned_ff;
      warm_valid_in  = warm_valid_ff;
      access_in      = access_ff;
      insert_in      = insert_ff;
      hot_bytes_in   = hot_bytes_ff;
      warm_bytes_in  = warm_bytes_ff;
      key_in         = key_ff;
      size_in        = size_ff;
      scan_key_in    = scan_key_ff;
      idx_in         = idx_ff;
      hhit_in        = hhit_ff;
      hhit_idx_in    = hhit_idx_ff;
      whit_in        = whit_ff;
      whit_idx_in    = whit_idx_ff;
      lru_in         = lru_ff;
      lru_idx_in     = lru_idx_ff;
      lru_age_in     = lru_age_ff;
      old_in         = old_ff;
      old_idx_in     = old_idx_ff;
      old_age_in     = old_age_ff;
      dem_key_in     = dem_key_ff;
      dem_size_in    = dem_size_ff;
      ev_key_in      = ev_key_ff;
      ev_size_in     = ev_size_ff;
      promo_in       = promo_ff;
      hot_wa         = hhit_idx_ff;
      hot_wkey       = key_ff;
      hot_wsize      = size_ff;
      hot_wr_data    = 1'b0;
      hot_wr_stamp   = 1'b0;
      warm_wa        = whit_ff ? whit_idx_ff : warm_free_idx;
      warm_wkey      = key_ff;
      warm_wsize     = size_ff;
      warm_wr        = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_code_in    = rsp_code_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_pres_in    = rsp_pres_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_hot_in     = rsp_hot_ff;
      rsp_warm_in    = rsp_warm_ff;
      hot_budget_in  = hot_budget_ff;
      warm_budget_in = warm_budget_ff;

      if (csr.valid) begin
         case (csr.index)
            REG_HOT_BUDGET:  hot_budget_in = csr.data;
            REG_WARM_BUDGET: warm_budget_in = csr.data;
            default: ;
         endcase
      end

      unique case (cmd.op)
         DP_LOAD, DP_SCAN_INIT, DP_SCAN_VIC: begin
            idx_in  = '0;
            hhit_in = 1'b0;
            whit_in = 1'b0;
            lru_in  = 1'b0;
            old_in  = 1'b0;
            if (cmd.op == DP_LOAD) begin
               key_in      = req_key;
               size_in     = req_size;
               scan_key_in = req_key;
            end else if (cmd.op == DP_SCAN_VIC) begin
               scan_key_in = hot_rd_key;
               dem_key_in  = hot_rd_key;
               dem_size_in = hot_rd_size;
            end
         end
         DP_STEP: begin
            idx_in = idx_ff + 1'b1;
            if (hot_in_range && hot_valid_ff[hot_ra]) begin
               if (!hhit_ff && hot_rd_key == scan_key_ff) begin
                  hhit_in     = 1'b1;
                  hhit_idx_in = hot_ra;
               end
               if (!hot_pinned_ff[hot_ra] && (!lru_ff || hot_age > lru_age_ff)) begin
                  lru_in     = 1'b1;
                  lru_idx_in = hot_ra;
                  lru_age_in = hot_age;
               end
            end
            if (warm_in_range && warm_valid_ff[warm_ra]) begin
               if (!whit_ff && warm_rd_key == scan_key_ff) begin
                  whit_in     = 1'b1;
                  whit_idx_in = warm_ra;
               end
               if (!old_ff || warm_age > old_age_ff) begin
                  old_in     = 1'b1;
                  old_idx_in = warm_ra;
                  old_age_in = warm_age;
               end
            end
         end
         DP_TOUCH: begin
            access_in    = access_ff + 1'b1;
            hot_wr_stamp = 1'b1;
         end
         DP_PROMOTE: begin
            warm_valid_in[whit_idx_ff] = 1'b0;
            warm_bytes_in              = warm_bytes_ff - USED_BITS'(warm_rd_size);
            hot_wa                     = hot_free_idx;
            hot_valid_in[hot_free_idx]  = 1'b1;
            hot_pinned_in[hot_free_idx] = 1'b0;
            hot_wsize    = warm_rd_size;
            hot_wr_data  = 1'b1;
            hot_wr_stamp = 1'b1;
            access_in    = access_ff + 1'b1;
            hot_bytes_in = hot_bytes_ff + USED_BITS'(warm_rd_size);
            promo_in     = warm_rd_size;
         end
         DP_PUT_HOT: begin
            if (hhit_ff) begin
               hot_bytes_in = hot_bytes_ff - USED_BITS'(hot_rd_size) + USED_BITS'(size_ff);
            end else begin
               hot_wa                      = hot_free_idx;
               hot_valid_in[hot_free_idx]  = 1'b1;
               hot_pinned_in[hot_free_idx] = 1'b0;
               hot_bytes_in = hot_bytes_ff + USED_BITS'(size_ff);
            end
            hot_wr_data  = 1'b1;
            hot_wr_stamp = 1'b1;
            access_in    = access_ff + 1'b1;
         end
         DP_PUT_WARM: begin
            warm_bytes_in = warm_bytes_ff - (whit_ff ? USED_BITS'(warm_rd_size) : '0)
                            + USED_BITS'(size_ff);
            warm_valid_in[warm_wa] = 1'b1;
            warm_wr   = 1'b1;
            insert_in = insert_ff + 1'b1;
         end
         DP_PIN: hot_pinned_in[hhit_idx_ff] = 1'b1;
         DP_CLEAR: begin
            hot_valid_in  = '0;
            hot_pinned_in = '0;
            warm_valid_in = '0;
            hot_bytes_in  = '0;
            warm_bytes_in = '0;
         end
         DP_DISCARD: begin
            warm_valid_in[old_idx_ff] = 1'b0;
            warm_bytes_in = warm_bytes_ff - USED_BITS'(warm_rd_size);
            ev_key_in     = warm_rd_key;
            ev_size_in    = warm_rd_size;
         end
         DP_DEMOTE: begin
            // The warm slot is the one holding the same key, else a free slot.
            warm_bytes_in = warm_bytes_ff - (whit_ff ? USED_BITS'(warm_rd_size) : '0)
                            + USED_BITS'(dem_size_ff);
            warm_valid_in[warm_wa]    = 1'b1;
            warm_wkey                 = dem_key_ff;
            warm_wsize                = dem_size_ff;
            warm_wr                   = 1'b1;
            insert_in                 = insert_ff + 1'b1;
            hot_valid_in[lru_idx_ff]  = 1'b0;
            hot_pinned_in[lru_idx_ff] = 1'b0;
            hot_bytes_in              = hot_bytes_ff - USED_BITS'(dem_size_ff);
            ev_key_in                 = dem_key_ff;
            ev_size_in                = dem_size_ff;
         end
         DP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = cmd.ev_code;
            rsp_key_in   = cmd.key_from_event ? ev_key_ff : key_ff;
            unique case (cmd.size_sel)
               SZ_REQ:   rsp_size_in = size_ff;
               SZ_HOT:   rsp_size_in = hot_rd_size;
               SZ_WARM:  rsp_size_in = warm_rd_size;
               SZ_EVENT: rsp_size_in = ev_size_ff;
               SZ_PROMO: rsp_size_in = promo_ff;
               default:  rsp_size_in = '0;
            endcase
            rsp_pres_in = cmd.with_present && (hhit_ff || whit_ff);
            rsp_last_in = cmd.last;
            rsp_hot_in  = hot_bytes_ff;
            rsp_warm_in = warm_bytes_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (hot_wr_data) begin
         hot_key_ff[hot_wa]  <= hot_wkey;
         hot_size_ff[hot_wa] <= hot_wsize;
      end
      if (hot_wr_stamp) begin
         hot_stamp_ff[hot_wa] <= access_in;
      end
      if (warm_wr) begin
         warm_key_ff[warm_wa]   <= warm_wkey;
         warm_size_ff[warm_wa]  <= warm_wsize;
         warm_order_ff[warm_wa] <= insert_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hot_valid_ff   <= '0;
         hot_pinned_ff  <= '0;
         warm_valid_ff  <= '0;
         access_ff      <= '0;
         insert_ff      <= '0;
         hot_bytes_ff   <= '0;
         warm_bytes_ff  <= '0;
         hot_budget_ff  <= '0;
         warm_budget_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         hot_valid_ff   <= hot_valid_in;
         hot_pinned_ff  <= hot_pinned_in;
         warm_valid_ff  <= warm_valid_in;
         access_ff      <= access_in;
         insert_ff      <= insert_in;
         hot_bytes_ff   <= hot_bytes_in;
         warm_bytes_ff  <= warm_bytes_in;
         hot_budget_ff  <= hot_budget_in;
         warm_budget_ff <= warm_budget_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      size_ff     <= size_in;
      scan_key_ff <= scan_key_in;
      idx_ff      <= idx_in;
      hhit_ff     <= hhit_in;
      hhit_idx_ff <= hhit_idx_in;
      whit_ff     <= whit_in;
      whit_idx_ff <= whit_idx_in;
      lru_ff      <= lru_in;
      lru_idx_ff  <= lru_idx_in;
      lru_age_ff  <= lru_age_in;
      old_ff      <= old_in;
      old_idx_ff  <= old_idx_in;
      old_age_ff  <= old_age_in;
      dem_key_ff  <= dem_key_in;
      dem_size_ff <= dem_size_in;
      ev_key_ff   <= ev_key_in;
      ev_size_ff  <= ev_size_in;
      promo_ff    <= promo_in;
      rsp_code_ff <= rsp_code_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_size_ff <= rsp_size_in;
      rsp_pres_ff <= rsp_pres_in;
      rsp_last_ff <= rsp_last_in;
      rsp_hot_ff  <= rsp_hot_in;
      rsp_warm_ff <= rsp_warm_in;
   end

   assign csr.ready      = 1'b1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_res  = rsp_code_ff;
   assign rsp.event_key  = rsp_key_ff;
   assign rsp.event_size = rsp_size_ff;
   assign rsp.present    = rsp_pres_ff;
   assign rsp.hot_used   = rsp_hot_ff;
   assign rsp.warm_used  = rsp_warm_ff;
   assign rsp.last       = rsp_last_ff;

   assign stat.scan_last = int'(idx_ff) == SCAN_LEN - 1;
   assign stat.hot_hit   = hhit_ff;
   assign stat.warm_hit  = whit_ff;
   assign stat.hot_free  = hot_free;
   assign stat.warm_free = warm_free;
   assign stat.lru_found = lru_ff;
   assign stat.old_found = old_ff;
   assign stat.hot_over  = BUDGET_BITS'(hot_bytes_ff) > hot_budget_ff;
   assign stat.warm_over = BUDGET_BITS'(warm_bytes_ff) > warm_budget_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp.ready;

endmodule

// File: hdl/ttcbm_ctrl.sv
// Request sequencer: decodes operations, runs scans and the eviction loops.
// Depends on ttcbm_pkg; drives the ttcbm_dp command port.
module ttcbm_ctrl
   import ttcbm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [OP_BITS-1:0] req_op,
   output logic               req_ready,
   input  status_type         stat,
   output cmd_type            cmd
);

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_RSCAN  = 16'h0002,
      S_DECIDE = 16'h0004,
      S_HCHK   = 16'h0008,
      S_LSCAN  = 16'h0010,
      S_LDEC   = 16'h0020,
      S_VSCAN  = 16'h0040,
      S_VDEC   = 16'h0080,
      S_DEMIT4 = 16'h0100,
      S_DEMOTE = 16'h0200,
      S_DEMIT3 = 16'h0400,
      S_WCHK   = 16'h0800,
      S_OSCAN  = 16'h1000,
      S_ODEC   = 16'h2000,
      S_WEMIT4 = 16'h4000,
      S_FINAL  = 16'h8000
   } state_type;

   state_type               state_ff, state_in;
   opcode_type              op_ff, op_in;
   logic [RES_CNT_BITS-1:0] res_ff, res_in;
   logic                    in_hot_ff, in_hot_in, fpres_ff, fpres_in;
   event_type               fcode_ff, fcode_in;
   size_sel_type            fsize_ff, fsize_in;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      res_in    = res_ff;
      in_hot_in = in_hot_ff;
      fpres_in  = fpres_ff;
      fcode_in  = fcode_ff;
      fsize_in  = fsize_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.op    = DP_NOP;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_op;
               res_in   = '0;
               cmd.op   = DP_LOAD;
               state_in = S_RSCAN;
            end
         end
         S_RSCAN, S_LSCAN, S_VSCAN, S_OSCAN: begin
            cmd.op = DP_STEP;
            if (stat.scan_last) begin
               unique case (state_ff)
                  S_RSCAN: state_in = S_DECIDE;
                  S_LSCAN: state_in = S_LDEC;
                  S_VSCAN: state_in = S_VDEC;
                  default: state_in = S_ODEC;
               endcase
            end
         end
         S_DECIDE: begin
            in_hot_in = 1'b1;
            fpres_in  = 1'b0;
            fcode_in  = EV_MISS;
            fsize_in  = SZ_ZERO;
            state_in  = S_FINAL;
            case (op_ff)
               OPC_GET: begin
                  if (stat.hot_hit) begin
                     cmd.op   = DP_TOUCH;
                     fcode_in = EV_HOT_HIT;
                     fsize_in = SZ_HOT;
                  end else if (stat.warm_hit && !stat.hot_free) begin
                     fcode_in = EV_FULL;
                     fsize_in = SZ_WARM;
                  end else if (stat.warm_hit) begin
                     cmd.op   = DP_PROMOTE;
                     fcode_in = EV_WARM_HIT;
                     fsize_in = SZ_PROMO;
                     state_in = S_HCHK;
                  end
               end
               OPC_PUT: begin
                  fsize_in = SZ_REQ;
                  if (stat.hot_hit || stat.hot_free) begin
                     cmd.op   = DP_PUT_HOT;
                     fcode_in = EV_DONE;
                     state_in = S_HCHK;
                  end else begin
                     fcode_in = EV_FULL;
                  end
               end
               OPC_PUTC: begin
                  fsize_in = SZ_REQ;
                  if (stat.warm_hit || stat.warm_free) begin
                     cmd.op    = DP_PUT_WARM;
                     fcode_in  = EV_DONE;
                     in_hot_in = 1'b0;
                     state_in  = S_WCHK;
                  end else begin
                     fcode_in = EV_FULL;
                  end
               end
               OPC_PIN: begin
                  if (stat.hot_hit) begin
                     cmd.op   = DP_PIN;
                     fcode_in = EV_DONE;
                     fsize_in = SZ_HOT;
                  end
               end
               OPC_CONTAINS: begin
                  fcode_in = EV_DONE;
                  fpres_in = 1'b1;
               end
               OPC_CLEAR: begin
                  cmd.op   = DP_CLEAR;
                  fcode_in = EV_DONE;
               end
               default: ;
            endcase
         end
         S_HCHK: begin
            // A demotion may need two result slots: a warm discard and the demotion.
            if (stat.hot_over && res_ff <= RES_CNT_BITS'(EVENT_CAP - 2)) begin
               cmd.op   = DP_SCAN_INIT;
               state_in = S_LSCAN;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_LDEC: begin
            if (stat.lru_found) begin
               cmd.op   = DP_SCAN_VIC;
               state_in = S_VSCAN;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_VDEC: begin
            if (stat.warm_hit || stat.warm_free) begin
               state_in = S_DEMOTE;
            end else begin
               cmd.op   = DP_DISCARD;
               state_in = S_DEMIT4;
            end
         end
         S_DEMIT4, S_DEMIT3, S_WEMIT4: begin
            if (stat.out_free) begin
               cmd.op             = DP_EMIT;
               cmd.ev_code        = (state_ff == S_DEMIT3) ? EV_DEMOTED : EV_DISCARDED;
               cmd.key_from_event = 1'b1;
               cmd.size_sel       = SZ_EVENT;
               res_in             = res_ff + 1'b1;
               unique case (state_ff)
                  S_DEMIT4: state_in = S_DEMOTE;
                  default:  state_in = S_WCHK;
               endcase
            end
         end
         S_DEMOTE: begin
            cmd.op   = DP_DEMOTE;
            state_in = S_DEMIT3;
         end
         S_WCHK: begin
            if (stat.warm_over && res_ff < RES_CNT_BITS'(EVENT_CAP)) begin
               cmd.op   = DP_SCAN_INIT;
               state_in = S_OSCAN;
            end else begin
               state_in = in_hot_ff ? S_HCHK : S_FINAL;
            end
         end
         S_ODEC: begin
            if (stat.old_found) begin
               cmd.op   = DP_DISCARD;
               state_in = S_WEMIT4;
            end else begin
               state_in = in_hot_ff ? S_HCHK : S_FINAL;
            end
         end
         S_FINAL: begin
            if (stat.out_free) begin
               cmd.op           = DP_EMIT;
               cmd.ev_code      = fcode_ff;
               cmd.size_sel     = fsize_ff;
               cmd.with_present = fpres_ff;
               cmd.last         = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      res_ff    <= res_in;
      in_hot_ff <= in_hot_in;
      fpres_ff  <= fpres_in;
      fcode_ff  <= fcode_in;
      fsize_ff  <= fsize_in;
   end

endmodule

// File: hdl/two_tier_cache_budget_manager_core.sv
// Channel    Direction  Contents
// req_chan   in         operation, key, chunk_size
// rsp_chan   out        event_res, event_key, event_size, present, hot_used, warm_used, last
// csr_chan   in         index (0 hot budget, 1 warm budget), data
//
// Every request runs one scan over the tag stores, one entry per cycle. Each demotion
// adds two scans; each warm discard under the warm budget check adds one scan. Results
// go through an output register, so a stalled response holds the sequencer only when
// it has a further result to deliver. Reset is synchronous; no clearing pass is needed.
// Depends on ttcbm_pkg, the channel interfaces, ttcbm_ctrl and ttcbm_dp.
`include "two_tier_cache_budget_manager_core_defines.svh"
module two_tier_cache_budget_manager_core
   import ttcbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ttcbm_req_if.sink   req_chan,
   ttcbm_rsp_if.source rsp_chan,
   ttcbm_csr_if.sink   csr_chan
);

   cmd_type    cmd;
   status_type stat;
   logic       req_ready;

   assign req_chan.ready = req_ready;

   ttcbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.operation),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ttcbm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_key  (req_chan.key),
      .req_size (req_chan.chunk_size),
      .csr      (csr_chan),
      .rsp      (rsp_chan)
   );

   `TTCBM_ASSERT(a_emit_needs_room, cmd.op == DP_EMIT |-> stat.out_free, "result dropped")
   `TTCBM_ASSERT_NEXT(a_busy_after_transfer, req_chan.valid && req_chan.ready, !req_chan.ready, "second request taken while busy")
   `TTCBM_ASSERT(a_evict_not_last, rsp_chan.valid && (rsp_chan.event_res == EV_DEMOTED || rsp_chan.event_res == EV_DISCARDED) |-> !rsp_chan.last, "eviction event marked last")
   `TTCBM_ASSERT(a_present_on_done, rsp_chan.valid && rsp_chan.present |-> rsp_chan.event_res == EV_DONE && rsp_chan.last, "present outside contains answer")

endmodule
